// ----- src/utf8_byte_stream_decoder_unit_defines.svh -----
// Assertion macros for the UTF-8 byte stream decoder.
`ifndef UTF8_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define UBSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define UBSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/ubsd_pkg.sv -----
// Package: types and constants of the UTF-8 byte stream decoder.
`timescale 1ns / 1ps

package ubsd_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    localparam logic [7:0] LEAD2_MASK = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF0;
    localparam logic [7:0] BITS4_MASK = 8'h07;
    localparam logic [7:0] BITS3_MASK = 8'h0F;
    localparam logic [7:0] BITS2_MASK = 8'h1F;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        logic [KIND_W-1:0]  kind;
    } ubsd_res_t;

endpackage

// ----- src/utf8_byte_stream_decoder_unit.sv -----
// Top level: UTF-8 byte stream decoder with a two-entry result buffer.
`timescale 1ns / 1ps
`include "utf8_byte_stream_decoder_unit_defines.svh"

// Usage
//   Input channel (in_valid/in_ready): one item per accepted cycle, either a
//   raw byte (in_byte) or an end-of-input marker (is_end = 1, byte ignored).
//   Output channel (out_valid/out_ready): one result per completed character
//   (kind 0), stray continuation byte (kind 1) or end marker (kind 2), with
//   code_point and byte_count. Lead and inner bytes of a multi-byte sequence
//   give no result; the result comes with the last byte.
// Output: a result is presented in the cycle after the item that causes it
//   is accepted when the head register is free; else it waits in the skid.
// Throughput: one item per cycle while in_ready is high. The decode is a single
//   pass of combinational logic from the accepted item and the sequence state
//   into the result register and the sequence state registers.
// Stall: a result register plus one skid entry sit on the output. While the
//   receiver stalls the block keeps taking items until one more result sits
//   in the skid entry; items that give no result never fill it. in_ready
//   drops once the skid entry is occupied and rises again the cycle after
//   the receiver takes a result.
// Reset: rst_n (asynchronous, active low) empties the result buffer and
//   returns the decoder to idle, with no open sequence.

module utf8_byte_stream_decoder_unit
    import ubsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               is_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CP_W-1:0]    code_point,
    output logic [COUNT_W-1:0] byte_count,
    output logic [KIND_W-1:0]  kind
);

    // Sequence state
    logic [1:0]         pending_reg, pending_next;
    logic [CP_W-1:0]    acc_reg, acc_next;
    logic [COUNT_W-1:0] taken_reg, taken_next;

    // Result buffer: head register and skid entry
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    ubsd_res_t out_reg, out_next;
    ubsd_res_t skid_reg, skid_next;

    logic      accept, take, has_res;
    ubsd_res_t res;
    logic [COUNT_W-1:0] taken_inc;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;
    assign taken_inc = taken_reg + COUNT_W'(1);

    // Decode one item against the open sequence
    always_comb
    begin
        has_res      = 1'b0;
        res          = '0;
        pending_next = pending_reg;
        acc_next     = acc_reg;
        taken_next   = taken_reg;
        if (is_end)
        begin
            // End marker drops any partial sequence
            has_res      = 1'b1;
            res.kind     = KIND_END;
            res.byte_count = taken_reg;
            pending_next = '0;
            acc_next     = '0;
            taken_next   = '0;
        end
        else if (pending_reg != 2'd0)
        begin
            // Inner byte: low six bits shifted in, top bits not checked
            acc_next     = {acc_reg[CP_W-7:0], in_byte[5:0]};
            taken_next   = taken_inc;
            pending_next = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                has_res        = 1'b1;
                res.kind       = KIND_CHAR;
                res.code_point = acc_next;
                res.byte_count = taken_inc;
                pending_next   = '0;
                acc_next       = '0;
                taken_next     = '0;
            end
        end
        else if (!in_byte[7])
        begin
            has_res        = 1'b1;
            res.kind       = KIND_CHAR;
            res.code_point = CP_W'(in_byte);
            res.byte_count = COUNT_W'(1);
        end
        else if ((in_byte & LEAD2_MASK) != LEAD2_MASK)
        begin
            // Stray continuation byte in lead position
            has_res        = 1'b1;
            res.kind       = KIND_ERROR;
            res.byte_count = COUNT_W'(1);
        end
        else
        begin
            taken_next = COUNT_W'(1);
            if ((in_byte & LEAD4_MASK) == LEAD4_MASK)
            begin
                acc_next     = CP_W'(in_byte & BITS4_MASK);
                pending_next = 2'd3;
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_MASK)
            begin
                acc_next     = CP_W'(in_byte & BITS3_MASK);
                pending_next = 2'd2;
            end
            else
            begin
                acc_next     = CP_W'(in_byte & BITS2_MASK);
                pending_next = 2'd1;
            end
        end
    end

    // Result buffer next state
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept && has_res)
        begin
            // skid is empty whenever an item is accepted
            if (out_valid_reg && !take)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            acc_reg        <= '0;
            taken_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
                taken_reg   <= taken_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = out_reg.code_point;
    assign byte_count = out_reg.byte_count;
    assign kind       = out_reg.kind;

    // Checks
    `UBSD_ASSERT_ALWAYS(a_skid_behind_head, skid_valid_reg |-> out_valid_reg,
        "skid entry holds a result while the head register is empty")
    `UBSD_ASSERT(a_idle_consistent, (pending_reg == 2'd0) |-> (taken_reg == '0),
        "no open sequence but bytes counted as taken")
    `UBSD_ASSERT(a_char_count, (out_valid_reg && kind == KIND_CHAR) |->
        (byte_count != '0 && byte_count <= COUNT_W'(4)),
        "character result with a byte count outside one to four")
    `UBSD_ASSERT(a_end_clears, (accept && is_end) |=> (pending_reg == 2'd0),
        "end marker left a sequence open")

endmodule
